>>> sv/jkv_pkg.sv
package jkv_pkg;

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_AFTER_KEY,
        PH_AFTER_COL,
        PH_STR_BODY,
        PH_STR_ESC,
        PH_INT_MINUS,
        PH_INT_DIGIT,
        PH_FIN_STR,
        PH_FIN_INT,
        PH_FIN_BAD
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_KEY    = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNTERM    = 3'd4;

    localparam logic [1:0] CFG_KEY_LO   = 2'd0;
    localparam logic [1:0] CFG_KEY_HI   = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;
    localparam logic [1:0] CFG_KIND     = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef struct packed {
        logic [7:0]         value_byte;
        logic               byte_valid;
        logic signed [63:0] int_value;
        logic [2:0]         status;
        logic               done_res;
    } result_t;

endpackage

>>> sv/json_key_value_extractor.sv
// JSON key/value extractor. Streams a JSON text one byte per item and looks for the first
// occurrence of the configured key in double quotes, then a colon, then the value. In string
// mode each decoded value byte comes out as its own result item (byte_valid high); in integer
// mode the signed 64-bit value comes with the final item. Every document ends with exactly one
// result item carrying done_res and the status, at most two result items follow any one input
// item. One input item per clock is sustained while the output queue has room: an item is
// registered, then evaluated against the 18-byte key window and the parse state, and its
// results go into a four-entry output queue. The user must write configuration between
// documents only; the block itself does not enforce it.
module json_key_value_extractor #(
    parameter int MAX_KEY_BYTES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         value_byte,
    output logic               byte_valid,
    output logic signed [63:0] int_value,
    output logic [2:0]         status,
    output logic               done_res
);
    import jkv_pkg::*;

    localparam int WIN    = MAX_KEY_BYTES + 2;
    localparam int SEEN_W = $clog2(WIN + 1);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration
    logic [63:0] key_lo_reg;
    logic [63:0] key_hi_reg;
    logic [4:0]  key_len_reg;
    logic        kind_reg;

    // input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_eot_reg;

    // parse state
    logic [WIN-1:0][7:0] win_reg, win_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    phase_t              phase_reg, phase_next;
    logic [63:0]         mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                ovf_reg, ovf_next;

    // output queue
    result_t             q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    logic        proc;
    logic        room;
    logic        pop;
    logic        match;
    logic [7:0]  c;
    logic        last;
    logic        is_ws;
    logic        is_dig;
    logic [63:0] limit;
    logic [67:0] prod;
    logic        add_ovf;
    logic        do_add;
    logic        emit_byte;
    logic [7:0]  emit_val;
    logic        emit_done;
    logic [2:0]  done_st;
    logic [63:0] done_iv;
    result_t     byte_res;
    result_t     done_res_w;
    logic [QCNT_W-1:0] push_n;

    assign c    = s1_byte_reg;
    assign last = s1_eot_reg;

    assign cfg_ready = 1'b1;
    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign proc      = s1_valid_reg && room;
    assign in_ready  = !s1_valid_reg || room;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;

    assign value_byte = q_mem[rd_ptr_reg].value_byte;
    assign byte_valid = q_mem[rd_ptr_reg].byte_valid;
    assign int_value  = q_mem[rd_ptr_reg].int_value;
    assign status     = q_mem[rd_ptr_reg].status;
    assign done_res   = q_mem[rd_ptr_reg].done_res;

    assign is_ws  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);

    // 10*m + d checked against the signed limit for the current sign
    assign limit   = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    assign prod    = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {64'd0, c[3:0]};
    assign add_ovf = prod > {4'd0, limit};

    always_comb
    begin
        win_next = win_reg;
        win_next[WIN-1:1] = win_reg[WIN-2:0];
        win_next[0] = c;
        seen_next = (seen_reg < SEEN_W'(WIN)) ? seen_reg + SEEN_W'(1) : seen_reg;
    end

    jkv_match #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_match (
        .window  (win_next),
        .seen    (seen_next),
        .key_lo  (key_lo_reg),
        .key_hi  (key_hi_reg),
        .key_len (key_len_reg),
        .match   (match)
    );

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        do_add     = 1'b0;
        emit_byte  = 1'b0;
        emit_val   = c;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (match)
                begin
                    phase_next = PH_AFTER_KEY;
                end
            end
            PH_AFTER_KEY:
            begin
                if (!is_ws)
                begin
                    phase_next = (c == CH_COLON) ? PH_AFTER_COL : PH_FIN_BAD;
                end
            end
            PH_AFTER_COL:
            begin
                if (!is_ws)
                begin
                    if (!kind_reg)
                    begin
                        phase_next = (c == CH_QUOTE) ? PH_STR_BODY : PH_FIN_BAD;
                    end
                    else if (c == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_INT_MINUS;
                    end
                    else if (is_dig)
                    begin
                        do_add     = 1'b1;
                        phase_next = PH_INT_DIGIT;
                    end
                    else
                    begin
                        phase_next = PH_FIN_BAD;
                    end
                end
            end
            PH_STR_BODY:
            begin
                if (c == CH_QUOTE)
                begin
                    phase_next = PH_FIN_STR;
                end
                else if ((c == CH_BSLASH) && !last)
                begin
                    phase_next = PH_STR_ESC;
                end
                else
                begin
                    emit_byte = 1'b1;
                end
            end
            PH_STR_ESC:
            begin
                emit_byte  = 1'b1;
                phase_next = PH_STR_BODY;
                case (c)
                    CH_N:    emit_val = CH_LF;
                    CH_R:    emit_val = CH_CR;
                    CH_T:    emit_val = CH_TAB;
                    default: emit_val = c;
                endcase
            end
            PH_INT_MINUS:
            begin
                if (is_dig)
                begin
                    do_add     = 1'b1;
                    phase_next = PH_INT_DIGIT;
                end
                else
                begin
                    phase_next = PH_FIN_BAD;
                end
            end
            PH_INT_DIGIT:
            begin
                if (is_dig)
                begin
                    do_add = 1'b1;
                end
                else
                begin
                    phase_next = PH_FIN_INT;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        mag_next = mag_reg;
        ovf_next = ovf_reg;
        if (do_add && !ovf_reg)
        begin
            if (add_ovf)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                mag_next = prod[63:0];
            end
        end
    end

    always_comb
    begin
        done_iv = '0;
        case (phase_next)
            PH_SEARCH:                 done_st = ST_NO_KEY;
            PH_STR_BODY, PH_STR_ESC:   done_st = ST_UNTERM;
            PH_FIN_STR:                done_st = ST_OK;
            PH_INT_DIGIT, PH_FIN_INT:
            begin
                if (ovf_next)
                begin
                    done_st = ST_OVERFLOW;
                end
                else
                begin
                    done_st = ST_OK;
                    done_iv = neg_next ? (64'd0 - mag_next) : mag_next;
                end
            end
            default:                   done_st = ST_MALFORMED;
        endcase
    end

    assign emit_done = last;

    always_comb
    begin
        byte_res            = '0;
        byte_res.value_byte = emit_val;
        byte_res.byte_valid = 1'b1;
        done_res_w           = '0;
        done_res_w.int_value = done_iv;
        done_res_w.status    = done_st;
        done_res_w.done_res  = 1'b1;
        push_n = proc ? (QCNT_W'(emit_byte) + QCNT_W'(emit_done)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
            key_len_reg <= '0;
            kind_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_LO:  key_lo_reg  <= cfg_data;
                CFG_KEY_HI:  key_hi_reg  <= cfg_data;
                CFG_KEY_LEN: key_len_reg <= cfg_data[4:0];
                CFG_KIND:    kind_reg    <= cfg_data[0];
                default:     kind_reg    <= kind_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= text_byte;
            s1_eot_reg  <= end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            seen_reg  <= '0;
            phase_reg <= PH_SEARCH;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else if (proc)
        begin
            if (last)
            begin
                win_reg   <= '0;
                seen_reg  <= '0;
                phase_reg <= PH_SEARCH;
                mag_reg   <= '0;
                neg_reg   <= 1'b0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (phase_reg == PH_SEARCH)
                begin
                    win_reg  <= win_next;
                    seen_reg <= seen_next;
                end
                phase_reg <= phase_next;
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            if (emit_byte)
            begin
                q_mem[wr_ptr_reg] <= byte_res;
                if (emit_done)
                begin
                    q_mem[wr_ptr_reg + QPTR_W'(1)] <= done_res_w;
                end
            end
            else if (emit_done)
            begin
                q_mem[wr_ptr_reg] <= done_res_w;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + push_n - QCNT_W'(pop);
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("output queue overfilled");

    a_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !byte_valid)
        else $error("final item flagged as value byte");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> (status == ST_OK) && (int_value == 64'sd0) && !done_res)
        else $error("value byte item carries status or integer");

    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc && s1_eot_reg |=> (phase_reg == PH_SEARCH) && (seen_reg == '0))
        else $error("document state not cleared after last byte");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !room |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("registered item lost while queue full");

endmodule

>>> sv/jkv_match.sv
module jkv_match #(
    parameter int MAX_KEY_BYTES = 16,
    parameter int WIN           = MAX_KEY_BYTES + 2,
    parameter int IDX_W         = $clog2(WIN),
    parameter int SEEN_W        = $clog2(WIN + 1)
) (
    input  logic [WIN-1:0][7:0] window,
    input  logic [SEEN_W-1:0]   seen,
    input  logic [63:0]         key_lo,
    input  logic [63:0]         key_hi,
    input  logic [4:0]          key_len,
    output logic                match
);
    import jkv_pkg::*;

    logic [127:0]     key_all;
    logic [IDX_W-1:0] len_c;
    logic [IDX_W-1:0] pos;
    logic             ok;

    assign key_all = {key_hi, key_lo};

    always_comb
    begin
        len_c = (key_len > 5'(MAX_KEY_BYTES)) ? IDX_W'(MAX_KEY_BYTES) : IDX_W'(key_len);
        ok    = (seen >= (SEEN_W'(len_c) + SEEN_W'(2)))
                && (window[0] == CH_QUOTE)
                && (window[len_c + IDX_W'(1)] == CH_QUOTE);
        pos   = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            pos = len_c - IDX_W'(i);
            if ((IDX_W'(i) < len_c) && (window[pos] != key_all[8*i +: 8]))
            begin
                ok = 1'b0;
            end
        end
        match = ok;
    end

endmodule
